@@ rtl/core/tsi_pkg.sv @@
// Shared types and constants of the trajectory sample interpolator.
// Holds the request and result payload structs, operation codes and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsi_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_ROWS_DEF    = 1024;
    localparam int JOINTS_DEF      = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    // Fixed field widths of the request and result channels.
    localparam int FUNC_W      = 2;
    localparam int ROW_W       = 10;
    localparam int JOINT_W     = 3;
    localparam int QTY_W       = 2;
    localparam int IN_W        = 32;
    localparam int OUT_W       = 32;
    localparam int QTY_N       = 4;

    // Configuration register widths and reset values.
    localparam int ROW_COUNT_W    = 11;
    localparam int PHASE_W        = 17;
    localparam int JOINT_EN_W     = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 17;
    localparam int ROW_COUNT_RST  = 2;
    localparam int PHASE_STEP_RST = 65536;
    localparam int MIN_ROWS       = 2;

    // Phase arithmetic: one whole row is 1.0 in Q1.16.
    localparam int ONE_ROW    = 65536;
    localparam int FRAC_W     = 16;
    localparam int ROUND_HALF = 32768;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_TICK  = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT     = 2'd0,
        CFG_PHASE_STEP    = 2'd1,
        CFG_REPEAT_ENABLE = 2'd2,
        CFG_JOINT_ENABLE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [ROW_W-1:0]        row;
        logic [JOINT_W-1:0]      joint;
        logic [QTY_W-1:0]        quantity;
        logic signed [IN_W-1:0]  sample_value;
    } t_req;

    typedef struct packed {
        logic [JOINT_W-1:0]      joint_id;
        logic signed [OUT_W-1:0] position;
        logic signed [OUT_W-1:0] velocity;
        logic signed [OUT_W-1:0] acceleration;
        logic signed [OUT_W-1:0] feedforward;
        logic                    done_res;
        logic                    last;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/core/tsi_stream_if.sv @@
// Valid/ready stream interface used for the request and result channels.
// The payload type is a parameter; the structs come from tsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tsi_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tsi_store.sv @@
// Trajectory row store: one write port and two registered read ports.
// Depends on tsi_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module tsi_store #(
    parameter int DEPTH       = tsi_pkg::MAX_ROWS_DEF * 32,
    parameter int VALUE_WIDTH = tsi_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  wire logic signed [VALUE_WIDTH-1:0] i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]      i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0]      i_rd_addr_b,
    output logic signed [VALUE_WIDTH-1:0]      o_rd_data_a,
    output logic signed [VALUE_WIDTH-1:0]      o_rd_data_b
);
    logic signed [VALUE_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end
endmodule

`default_nettype wire

@@ rtl/core/tsi_interp.sv @@
// Serial linear interpolator: a + round((b - a) * phase / 2^16), one phase bit a cycle.
// Depends on tsi_pkg for the phase and output widths.
`timescale 1ns / 1ps
`default_nettype none

module tsi_interp #(
    parameter int VALUE_WIDTH = tsi_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [VALUE_WIDTH-1:0]     i_a,
    input  wire logic signed [VALUE_WIDTH-1:0]     i_b,
    input  wire logic [tsi_pkg::PHASE_W-1:0]       i_phase,
    output logic                                   o_done,
    output logic signed [tsi_pkg::OUT_W-1:0]       o_value
);
    import tsi_pkg::*;

    localparam int DW    = VALUE_WIDTH + 1;
    localparam int PW    = DW + PHASE_W + 1;
    localparam int CNT_W = $clog2(PHASE_W);

    logic                    r_busy;
    logic                    r_fin;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [PW-1:0]    r_acc;
    logic signed [PW-1:0]    r_mcand;
    logic [PHASE_W-1:0]      r_mult;
    logic signed [VALUE_WIDTH-1:0] r_a;
    logic signed [OUT_W-1:0] r_value;

    logic signed [DW-1:0]    w_diff;
    logic signed [PW-1:0]    w_sum;
    logic signed [PW-1:0]    w_v;

    assign w_diff = DW'(i_b) - DW'(i_a);
    assign w_sum  = r_acc + (r_mult[0] ? r_mcand : PW'(0));
    // Arithmetic shift floors, which with the half added up front rounds half up.
    assign w_v    = PW'(r_a) + (r_acc >>> FRAC_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(PHASE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= PW'(ROUND_HALF);
            r_mcand <= PW'(w_diff);
            r_mult  <= i_phase;
            r_a     <= i_a;
        end else if (r_busy) begin
            r_acc   <= w_sum;
            r_mcand <= r_mcand <<< 1;
            r_mult  <= r_mult >> 1;
        end else if (r_fin) begin
            // The result lies between a and b, so the low bits carry it exactly.
            r_value <= w_v[OUT_W-1:0];
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;
endmodule

`default_nettype wire

@@ rtl/core/trajectory_sample_interpolator_top.sv @@
// Top level of the trajectory sample interpolator: playback control and result register.
// Depends on tsi_pkg, tsi_stream_if, tsi_store and tsi_interp.
`timescale 1ns / 1ps
`default_nettype none

// The block plays back a trajectory held in an on-chip row store. A load request
// writes one signed Q15.16 sample (position, velocity, acceleration or feedforward)
// for one row and joint; loads with a row at or above MAX_ROWS or a joint at or
// above JOINTS are dropped. The store is not cleared at reset, so every entry that
// playback will read must be loaded first; results built from unloaded entries are
// meaningless. A start request rewinds to row 0 with phase 0. Each tick request adds
// the phase step (Q1.16, clamped to one row) and walks forward over whole rows; at
// the last row it wraps with phase equal to the step when repeat is on, otherwise
// it ends playback. A tick then returns one result per enabled joint with the
// interpolated values, the last of them flagged, or a single done result with all
// values zero once playback has ended. Load and start requests return nothing. A tick
// walks the advance state over each row step or wrap and the scan state over each
// disabled joint that is skipped; each enabled joint takes a scan, an emit and four
// quantities, each a store read, an interpolator start and then the shared serial
// interpolator that handles one phase bit per cycle. A receiver that holds off
// stretches the emit state. Configuration registers may be written only while no
// request is in flight.
module trajectory_sample_interpolator_top #(
    parameter int MAX_ROWS    = tsi_pkg::MAX_ROWS_DEF,
    parameter int JOINTS      = tsi_pkg::JOINTS_DEF,
    parameter int VALUE_WIDTH = tsi_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [tsi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tsi_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    tsi_stream_if.sink                            i_req,
    tsi_stream_if.source                          o_res
);
    import tsi_pkg::*;

    // Segment register width, row count compare width and store address width.
    localparam int SW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (SW + 1 > ROW_COUNT_W) ? SW + 1 : ROW_COUNT_W;
    localparam int DEPTH = MAX_ROWS * (2 ** (JOINT_W + QTY_W));
    localparam int AW    = $clog2(DEPTH);
    localparam int PACC_W = PHASE_W + 1;
    localparam logic [JOINT_EN_W-1:0] JMASK  = JOINT_EN_W'((1 << JOINTS) - 1);
    localparam logic [JOINT_W-1:0]    LAST_J = JOINT_W'(JOINTS - 1);

    // One-hot playback sequencer.
    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_ADVANCE = 7'b0000010,
        ST_SCAN    = 7'b0000100,
        ST_READ    = 7'b0001000,
        ST_MSTART  = 7'b0010000,
        ST_MUL     = 7'b0100000,
        ST_EMIT    = 7'b1000000
    } t_state;

    // The done result is emitted from ST_EMIT with r_emit_done set.
    t_state r_state, n_state;

    // Configuration registers.
    logic [ROW_COUNT_W-1:0] r_row_count;
    logic [PHASE_W-1:0]     r_phase_step;
    logic                   r_repeat;
    logic [JOINT_EN_W-1:0]  r_joint_en;

    // Playback state.
    logic [SW-1:0]          r_seg, n_seg;
    logic [PACC_W-1:0]      r_phase, n_phase;
    logic                   r_wrapped, n_wrapped;
    logic                   r_finished, n_finished;
    logic                   r_emit_done, n_emit_done;
    logic [JOINT_W-1:0]     r_joint, n_joint;
    logic [QTY_W-1:0]       r_q, n_q;

    // Interpolated values of the current joint and the output register.
    logic [OUT_W-1:0]       r_val [QTY_N];
    t_res                   r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    // Store and interpolator connections.
    logic                          w_wr_en;
    logic [AW-1:0]                 w_wr_addr;
    logic signed [VALUE_WIDTH-1:0] w_wr_data;
    logic                          w_rd_en;
    logic [AW-1:0]                 w_rd_addr_a;
    logic [AW-1:0]                 w_rd_addr_b;
    logic signed [VALUE_WIDTH-1:0] w_rd_data_a;
    logic signed [VALUE_WIDTH-1:0] w_rd_data_b;
    logic                          w_mul_start;
    logic                          w_mul_done;
    logic signed [OUT_W-1:0]       w_mul_value;

    logic                   w_req_fire;
    logic                   w_slot_free;
    logic [CW-1:0]          w_rows;
    logic [SW-1:0]          w_seg_next;
    logic                   w_at_end;
    logic [PHASE_W-1:0]     w_step;
    logic [JOINT_EN_W-1:0]  w_en;
    logic [JOINT_EN_W-1:0]  w_rest;
    logic                   w_more;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_req_fire  = i_req.valid && (r_state == ST_IDLE);
    assign w_slot_free = !r_out_valid || o_res.ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // Row count in use, clamped to at least two rows and at most the store size.
    always_comb begin
        w_rows = CW'(r_row_count);
        if (w_rows < CW'(MIN_ROWS)) begin
            w_rows = CW'(MIN_ROWS);
        end
        if (w_rows > CW'(MAX_ROWS)) begin
            w_rows = CW'(MAX_ROWS);
        end
    end

    assign w_seg_next = SW'(CW'(r_seg) + CW'(1));
    assign w_at_end   = (CW'(r_seg) + CW'(1)) >= w_rows;
    assign w_step     = (r_phase_step > PHASE_W'(ONE_ROW)) ? PHASE_W'(ONE_ROW) : r_phase_step;

    // Enabled joints, and whether any enabled joint follows the current one.
    assign w_en   = r_joint_en & JMASK;
    assign w_rest = w_en >> r_joint;
    assign w_more = |w_rest[JOINT_EN_W-1:1];

    // A load writes the store in the cycle it is accepted; reads come only later.
    assign w_wr_en = w_req_fire && (i_req.payload.func == FUNC_LOAD)
                     && (32'(i_req.payload.row) < MAX_ROWS)
                     && (32'(i_req.payload.joint) < JOINTS);
    assign w_wr_addr = {SW'(i_req.payload.row), i_req.payload.joint, i_req.payload.quantity};
    assign w_wr_data = VALUE_WIDTH'(i_req.payload.sample_value);

    assign w_rd_en     = (r_state == ST_READ);
    assign w_rd_addr_a = {r_seg, r_joint, r_q};
    assign w_rd_addr_b = {w_seg_next, r_joint, r_q};
    assign w_mul_start = (r_state == ST_MSTART);

    tsi_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_en     (w_rd_en),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

    tsi_interp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_rd_data_a),
        .i_b     (w_rd_data_b),
        .i_phase (r_phase[PHASE_W-1:0]),
        .o_done  (w_mul_done),
        .o_value (w_mul_value)
    );

    // Sequencer. The tick first walks the phase over whole rows one step a cycle,
    // then visits every enabled joint, interpolating its four quantities in turn, or emits the done result.
    always_comb begin
        n_state     = r_state;
        n_seg       = r_seg;
        n_phase     = r_phase;
        n_wrapped   = r_wrapped;
        n_finished  = r_finished;
        n_emit_done = r_emit_done;
        n_joint     = r_joint;
        n_q         = r_q;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;

        unique case (r_state)
            ST_IDLE: begin
                if (w_req_fire) begin
                    unique case (i_req.payload.func)
                        FUNC_START: begin
                            n_seg      = '0;
                            n_phase    = '0;
                            n_finished = 1'b0;
                        end
                        FUNC_TICK: begin
                            if (r_finished) begin
                                n_emit_done = 1'b1;
                                n_state     = ST_EMIT;
                            end else begin
                                n_phase   = r_phase + PACC_W'(w_step);
                                n_wrapped = 1'b0;
                                n_state   = ST_ADVANCE;
                            end
                        end
                        default: begin
                            // Loads are written to the store directly; other codes
                            // are ignored.
                        end
                    endcase
                end
            end
            ST_ADVANCE: begin
                priority if (w_at_end) begin
                    if (r_repeat) begin
                        n_seg   = '0;
                        n_phase = PACC_W'(w_step);
                        if (r_wrapped) begin
                            // A second wrap within one tick stops the walk.
                            n_joint = '0;
                            n_state = ST_SCAN;
                        end else begin
                            n_wrapped = 1'b1;
                        end
                    end else begin
                        n_finished  = 1'b1;
                        n_emit_done = 1'b1;
                        n_state     = ST_EMIT;
                    end
                end else if (r_phase >= PACC_W'(ONE_ROW)) begin
                    n_phase = r_phase - PACC_W'(ONE_ROW);
                    n_seg   = r_seg + SW'(1);
                end else begin
                    n_joint = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                priority if (w_en[r_joint]) begin
                    n_q     = '0;
                    n_state = ST_READ;
                end else if (r_joint == LAST_J) begin
                    n_state = ST_IDLE;
                end else begin
                    n_joint = r_joint + JOINT_W'(1);
                end
            end
            ST_READ: begin
                n_state = ST_MSTART;
            end
            ST_MSTART: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (w_mul_done) begin
                    if (r_q == QTY_W'(QTY_N - 1)) begin
                        n_emit_done = 1'b0;
                        n_state     = ST_EMIT;
                    end else begin
                        n_q     = r_q + QTY_W'(1);
                        n_state = ST_READ;
                    end
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_emit_done) begin
                        n_out.joint_id     = '0;
                        n_out.position     = '0;
                        n_out.velocity     = '0;
                        n_out.acceleration = '0;
                        n_out.feedforward  = '0;
                        n_out.done_res     = 1'b1;
                        n_out.last         = 1'b1;
                        n_emit_done        = 1'b0;
                        n_state            = ST_IDLE;
                    end else begin
                        n_out.joint_id     = r_joint;
                        n_out.position     = r_val[0];
                        n_out.velocity     = r_val[1];
                        n_out.acceleration = r_val[2];
                        n_out.feedforward  = r_val[3];
                        n_out.done_res     = 1'b0;
                        n_out.last         = !w_more;
                        if (w_more) begin
                            n_joint = r_joint + JOINT_W'(1);
                            n_state = ST_SCAN;
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seg        <= '0;
            r_phase      <= '0;
            r_wrapped    <= 1'b0;
            r_finished   <= 1'b0;
            r_emit_done  <= 1'b0;
            r_joint      <= '0;
            r_q          <= '0;
            r_out_valid  <= 1'b0;
            r_row_count  <= ROW_COUNT_W'(ROW_COUNT_RST);
            r_phase_step <= PHASE_W'(PHASE_STEP_RST);
            r_repeat     <= 1'b0;
            r_joint_en   <= '0;
        end else begin
            r_state     <= n_state;
            r_seg       <= n_seg;
            r_phase     <= n_phase;
            r_wrapped   <= n_wrapped;
            r_finished  <= n_finished;
            r_emit_done <= n_emit_done;
            r_joint     <= n_joint;
            r_q         <= n_q;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_ROW_COUNT:     r_row_count  <= i_cfg_wdata[ROW_COUNT_W-1:0];
                    CFG_PHASE_STEP:    r_phase_step <= i_cfg_wdata[PHASE_W-1:0];
                    CFG_REPEAT_ENABLE: r_repeat     <= i_cfg_wdata[0];
                    CFG_JOINT_ENABLE:  r_joint_en   <= i_cfg_wdata[JOINT_EN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if ((r_state == ST_MUL) && w_mul_done) begin
            r_val[r_q] <= w_mul_value;
        end
    end
endmodule

`default_nettype wire

@@ tb/tb_trajectory_sample_interpolator_top.sv @@
// Self-checking testbench for trajectory_sample_interpolator_top: directed and random requests.
// Predicts each result from its own copy of store, playback state and registers.
// Depends on tsi_pkg, tsi_stream_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_trajectory_sample_interpolator_top;

    import tsi_pkg::*;

    // Run size and time limits. The long receiver hold-off adds to the time that a
    // tick with all eight joints enabled keeps the block busy. The watchdog allows
    // several times the worst gap.
    localparam int ITEMS_TOTAL    = 470;
    localparam int SETTLE_CYCLES  = 32;
    localparam int TAIL_CYCLES    = 100;
    localparam int LONG_HOLD      = 1500;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int MAX_REPORTS    = 40;

    // Function code that the block does not use. Its requests must be dropped.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam logic [QTY_W-1:0] QTY_POS = 2'd0;
    localparam logic [QTY_W-1:0] QTY_VEL = 2'd1;
    localparam logic [QTY_W-1:0] QTY_ACC = 2'd2;
    localparam logic [QTY_W-1:0] QTY_FF  = 2'd3;

    localparam t_res DONE_RESULT = '{joint_id: '0, position: '0, velocity: '0,
                                     acceleration: '0, feedforward: '0,
                                     done_res: 1'b1, last: 1'b1};

    // How the expectation of a request is obtained. Most requests use the
    // predictor. Some directed rows type the answer in directly.
    typedef enum {EXP_MODEL, EXP_NONE, EXP_DONE} t_exp_kind;

    typedef struct {
        bit                      is_cfg;
        t_cfg_idx                reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        t_req                    req;
        t_exp_kind               kind;
    } t_plan_row;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    tsi_stream_if #(.t_payload(t_req)) req_if ();
    tsi_stream_if #(.t_payload(t_res)) res_if ();

    trajectory_sample_interpolator_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state. It mirrors the row store, the playback position and the
    // four registers. The loaded flags let the stimulus avoid reading a store
    // entry that was never written.
    logic signed [IN_W-1:0] traj_rows  [MAX_ROWS_DEF][JOINTS_DEF][QTY_N];
    bit                     row_loaded [MAX_ROWS_DEF][JOINTS_DEF][QTY_N];
    int unsigned            play_seg   = 0;
    int unsigned            play_ph    = 0;
    bit                     play_done  = 1'b0;
    logic [ROW_COUNT_W-1:0] cfg_rows   = ROW_COUNT_W'(ROW_COUNT_RST);
    logic [PHASE_W-1:0]     cfg_step   = PHASE_W'(PHASE_STEP_RST);
    bit                     cfg_repeat = 1'b0;
    logic [JOINT_EN_W-1:0]  cfg_jen    = '0;

    t_res      pending_results [$];
    t_plan_row plan [$];

    // Run bookkeeping.
    bit quiet       = 1'b0;
    int hold_asked  = 0;
    int hold_served = 0;
    int mismatches  = 0;
    int req_total   = 0;
    int n_loads     = 0;
    int n_starts    = 0;
    int n_ticks     = 0;
    int n_unused    = 0;
    int settings    = 0;
    int results_seen = 0;
    int done_seen   = 0;
    int stall_run   = 0;
    int phase_no    = 0;
    t_res got_now;
    t_res expected_now;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Linear blend in Q1.16 with rounding half toward plus infinity. The
    // arithmetic shift floors, which matches that rounding for both signs.
    function automatic logic signed [OUT_W-1:0] blend_q16(logic signed [IN_W-1:0] a,
                                                          logic signed [IN_W-1:0] b,
                                                          int unsigned ph);
        longint acc;
        acc = (longint'(b) - longint'(a)) * longint'(ph) + ROUND_HALF;
        acc = longint'(a) + (acc >>> FRAC_W);
        return acc[OUT_W-1:0];
    endfunction

    // One tick of playback on the given position. Row count is clamped to
    // the legal range and the step to one whole row. At the last row the
    // segment wraps with the phase set to one step, or playback ends. A
    // second wrap in the same tick stops the walk.
    function automatic void advance_playback(inout int unsigned seg, inout int unsigned ph,
                                             inout bit fin);
        int unsigned rows;
        int unsigned stp;
        int unsigned wraps;
        if (fin) return;
        rows = (cfg_rows < MIN_ROWS) ? MIN_ROWS : cfg_rows;
        if (rows > MAX_ROWS_DEF) rows = MAX_ROWS_DEF;
        stp = (cfg_step > ONE_ROW) ? ONE_ROW : cfg_step;
        ph += stp;
        wraps = 0;
        while (1) begin
            if (seg + 1 >= rows) begin
                if (!cfg_repeat) begin
                    fin = 1'b1;
                    break;
                end
                seg = 0;
                ph = stp;
                wraps++;
                if (wraps >= 2) break;
            end else if (ph >= ONE_ROW) begin
                ph -= ONE_ROW;
                seg++;
            end else begin
                break;
            end
        end
    endfunction

    // Applies one request to the predictor state and queues what it causes.
    function automatic void playback_predict(t_req r, t_exp_kind kind);
        t_res res;
        int   n;
        n = 0;
        case (r.func)
            FUNC_LOAD: begin
                traj_rows[r.row][r.joint][r.quantity]  = r.sample_value;
                row_loaded[r.row][r.joint][r.quantity] = 1'b1;
            end
            FUNC_START: begin
                play_seg  = 0;
                play_ph   = 0;
                play_done = 1'b0;
            end
            FUNC_TICK: begin
                advance_playback(play_seg, play_ph, play_done);
                if (kind == EXP_MODEL && play_done) begin
                    pending_results.push_back(DONE_RESULT);
                end else if (kind == EXP_MODEL) begin
                    for (int j = 0; j < JOINTS_DEF; j++) begin
                        if (cfg_jen[j]) begin
                            res              = '0;
                            res.joint_id     = JOINT_W'(j);
                            res.position     = blend_q16(traj_rows[play_seg][j][QTY_POS],
                                                         traj_rows[play_seg + 1][j][QTY_POS],
                                                         play_ph);
                            res.velocity     = blend_q16(traj_rows[play_seg][j][QTY_VEL],
                                                         traj_rows[play_seg + 1][j][QTY_VEL],
                                                         play_ph);
                            res.acceleration = blend_q16(traj_rows[play_seg][j][QTY_ACC],
                                                         traj_rows[play_seg + 1][j][QTY_ACC],
                                                         play_ph);
                            res.feedforward  = blend_q16(traj_rows[play_seg][j][QTY_FF],
                                                         traj_rows[play_seg + 1][j][QTY_FF],
                                                         play_ph);
                            pending_results.push_back(res);
                            n++;
                        end
                    end
                    if (n > 0) pending_results[pending_results.size() - 1].last = 1'b1;
                end
            end
            default: ;
        endcase
        if (kind == EXP_DONE) pending_results.push_back(DONE_RESULT);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_req mk_req(logic [FUNC_W-1:0] f, int unsigned row, int unsigned jnt,
                                    int unsigned qty, logic [IN_W-1:0] val);
        t_req r;
        r.func         = f;
        r.row          = ROW_W'(row);
        r.joint        = JOINT_W'(jnt);
        r.quantity     = QTY_W'(qty);
        r.sample_value = val;
        return r;
    endfunction

    // Sample values lean on the extremes of Q15.16 so that the blend sees
    // the widest differences in both directions.
    function automatic logic [IN_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4: return IN_W'($urandom_range(0, 2 * ONE_ROW)) - IN_W'(ONE_ROW);
            default: return $urandom;
        endcase
    endfunction

    function automatic void plan_cfg(t_cfg_idx idx, int unsigned val);
        t_plan_row p;
        p.is_cfg  = 1'b1;
        p.reg_idx = idx;
        p.reg_val = CFG_DATA_W'(val);
        p.req     = '0;
        p.kind    = EXP_NONE;
        plan.push_back(p);
    endfunction

    function automatic void plan_req(t_req r, t_exp_kind kind);
        t_plan_row p;
        p.is_cfg  = 1'b0;
        p.reg_idx = CFG_ROW_COUNT;
        p.reg_val = '0;
        p.req     = r;
        p.kind    = kind;
        plan.push_back(p);
    endfunction

    task automatic flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string fname, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                    results_seen, fname, got, want));
    endtask

    // Offers one request and returns at the edge where it is taken. The valid
    // stays high so that a following request goes out without a bubble.
    task automatic push_req(t_req r);
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // Drops valid and waits until every queued result has come back. The
    // extra cycles cover a tick that ends without any result.
    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The write port has no handshake. The write lands at the next edge and
    // is mirrored into the predictor there.
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ROW_COUNT:     cfg_rows   = val[ROW_COUNT_W-1:0];
            CFG_PHASE_STEP:    cfg_step   = val[PHASE_W-1:0];
            CFG_REPEAT_ENABLE: cfg_repeat = val[0];
            CFG_JOINT_ENABLE:  cfg_jen    = val[JOINT_EN_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one request. A tick is preceded by loads of any store entry it
    // would read that has not been written yet.
    task automatic send(t_req r, t_exp_kind kind = EXP_MODEL);
        if (r.func == FUNC_TICK) preload_for_tick();
        playback_predict(r, kind);
        push_req(r);
        case (r.func)
            FUNC_LOAD:  n_loads++;
            FUNC_START: n_starts++;
            FUNC_TICK:  n_ticks++;
            default:    n_unused++;
        endcase
        if (r.func != FUNC_UNUSED) req_total++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Looks one tick ahead and fills the two rows it will blend for every
    // enabled joint. A tick that ends playback reads nothing.
    task automatic preload_for_tick();
        int unsigned seg;
        int unsigned ph;
        bit          fin;
        seg = play_seg;
        ph  = play_ph;
        fin = play_done;
        advance_playback(seg, ph, fin);
        if (fin) return;
        for (int j = 0; j < JOINTS_DEF; j++) begin
            for (int k = 0; k < 2; k++) begin
                for (int q = 0; q < QTY_N; q++) begin
                    if (cfg_jen[j] && !row_loaded[seg + k][j][q])
                        send(mk_req(FUNC_LOAD, seg + k, j, q, random_sample()));
                end
            end
        end
    endtask

    // A stray request: a load anywhere in the store, the unused code, a
    // rewind or a tick.
    task automatic send_noise();
        case ($urandom_range(0, 5))
            0, 1, 2: send(mk_req(FUNC_LOAD, $urandom_range(0, MAX_ROWS_DEF - 1),
                                 $urandom_range(0, JOINTS_DEF - 1),
                                 $urandom_range(0, QTY_N - 1), random_sample()));
            3: send(mk_req(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom));
            4: send(mk_req(FUNC_START, $urandom, $urandom, $urandom, $urandom));
            default: send(mk_req(FUNC_TICK, $urandom, $urandom, $urandom, $urandom));
        endcase
    endtask

    // Row counts stay small most of the time. Out-of-range values are
    // included so that the clamping is exercised.
    function automatic int unsigned pick_rows();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return (1 << ROW_COUNT_W) - 1;
            3: return MAX_ROWS_DEF;
            default: return $urandom_range(MIN_ROWS, 6);
        endcase
    endfunction

    function automatic int unsigned pick_step();
        case ($urandom_range(0, 7))
            0: return ONE_ROW;
            1: return ONE_ROW / 2;
            2: return 0;
            3: return $urandom_range(ONE_ROW + 1, (1 << PHASE_W) - 1);
            4: return 1;
            default: return $urandom_range(1, ONE_ROW);
        endcase
    endfunction

    function automatic int unsigned pick_joints();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return (1 << JOINT_EN_W) - 1;
            default: return $urandom_range(0, (1 << JOINT_EN_W) - 1);
        endcase
    endfunction

    // One random phase: new settings, then mostly a proper playback run with
    // random content, sometimes a burst of stray requests. The squeeze phase
    // asks the receiver for a long hold-off while ticks keep coming.
    task automatic run_phase(bit squeeze);
        int n;
        settle();
        write_reg(CFG_ROW_COUNT, CFG_DATA_W'(pick_rows()));
        write_reg(CFG_PHASE_STEP, CFG_DATA_W'(pick_step()));
        write_reg(CFG_REPEAT_ENABLE, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(CFG_JOINT_ENABLE,
                  squeeze ? CFG_DATA_W'((1 << JOINT_EN_W) - 1) : CFG_DATA_W'(pick_joints()));
        settings++;
        if (squeeze) begin
            send(mk_req(FUNC_START, 0, 0, 0, 0));
            hold_asked++;
            repeat (6) send(mk_req(FUNC_TICK, 0, 0, 0, 0));
        end else if ($urandom_range(0, 4) != 0) begin
            // Skipping the rewind keeps playback going under new settings,
            // which also covers a segment left past a lowered row count.
            if ($urandom_range(0, 3) != 0) send(mk_req(FUNC_START, $urandom, 0, 0, $urandom));
            n = $urandom_range(2, 10);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                send(mk_req(FUNC_TICK, $urandom, $urandom, $urandom, $urandom));
            end
        end else begin
            n = $urandom_range(3, 10);
            repeat (n) send_noise();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready with bursts of back-pressure, plus one long
    // hold-off on request. Near the end of the run ready stays high.
    // ------------------------------------------------------------------
    initial begin
        res_if.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_asked != hold_served) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_served++;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker and watchdog. Values are sampled at the clock edge, so
    // they are the ones that were stable before it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                got_now = res_if.payload;
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("result %0d for joint %0d with nothing expected",
                                            results_seen, got_now.joint_id));
                end else begin
                    expected_now = pending_results.pop_front();
                    if (expected_now.done_res) done_seen++;
                    check_field("joint_id", OUT_W'(got_now.joint_id),
                                OUT_W'(expected_now.joint_id));
                    check_field("position", got_now.position, expected_now.position);
                    check_field("velocity", got_now.velocity, expected_now.velocity);
                    check_field("acceleration", got_now.acceleration,
                                expected_now.acceleration);
                    check_field("feedforward", got_now.feedforward, expected_now.feedforward);
                    check_field("done_res", OUT_W'(got_now.done_res),
                                OUT_W'(expected_now.done_res));
                    check_field("last", OUT_W'(got_now.last), OUT_W'(expected_now.last));
                end
            end
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_wr_en)
                stall_run = 0;
            else
                stall_run++;
            if (stall_run >= WATCHDOG_LIMIT) begin
                $display("timeout: nothing moved for %0d cycles, %0d results outstanding",
                         stall_run, pending_results.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;

        // Directed table. With the settings from reset, a tick walks
        // straight past the second row and ends playback, so the done result
        // is known without the predictor. The unused code and the loads and
        // rewinds return nothing. A done state persists until a rewind.
        plan_req(mk_req(FUNC_TICK, 0, 0, 0, 0), EXP_DONE);
        plan_req(mk_req(FUNC_UNUSED, 1023, 7, 3, 32'hFFFF_FFFF), EXP_NONE);
        plan_req(mk_req(FUNC_TICK, 0, 0, 0, 0), EXP_DONE);
        plan_req(mk_req(FUNC_START, 0, 0, 0, 0), EXP_NONE);

        // A row count below the minimum, a quarter-row step and repeat. The
        // top joint gets full-scale samples of opposite sign on the two rows.
        plan_cfg(CFG_ROW_COUNT, 0);
        plan_cfg(CFG_PHASE_STEP, ONE_ROW / 4);
        plan_cfg(CFG_REPEAT_ENABLE, 1);
        plan_cfg(CFG_JOINT_ENABLE, 1 << (JOINTS_DEF - 1));
        plan_req(mk_req(FUNC_LOAD, 0, JOINTS_DEF - 1, QTY_POS, 32'h7FFF_FFFF), EXP_NONE);
        plan_req(mk_req(FUNC_LOAD, 1, JOINTS_DEF - 1, QTY_POS, 32'h8000_0000), EXP_NONE);
        plan_req(mk_req(FUNC_LOAD, 0, JOINTS_DEF - 1, QTY_VEL, 32'h8000_0000), EXP_NONE);
        plan_req(mk_req(FUNC_LOAD, 1, JOINTS_DEF - 1, QTY_VEL, 32'h7FFF_FFFF), EXP_NONE);
        plan_req(mk_req(FUNC_LOAD, MAX_ROWS_DEF - 1, 0, QTY_FF, 32'hFFFF_FFFF), EXP_NONE);
        plan_req(mk_req(FUNC_START, 0, 0, 0, 0), EXP_NONE);
        // Four quarter steps; the fourth wraps back to the first row.
        repeat (4) plan_req(mk_req(FUNC_TICK, 0, 0, 0, 0), EXP_MODEL);

        // A whole-row step on two rows wraps twice in one tick.
        plan_cfg(CFG_PHASE_STEP, ONE_ROW);
        plan_req(mk_req(FUNC_TICK, 0, 0, 0, 0), EXP_MODEL);
        // A zero step still walks on the whole row that the phase holds and wraps.
        plan_cfg(CFG_PHASE_STEP, 0);
        plan_req(mk_req(FUNC_TICK, 0, 0, 0, 0), EXP_MODEL);

        // Row count and step above their limits are clamped.
        plan_cfg(CFG_ROW_COUNT, (1 << ROW_COUNT_W) - 1);
        plan_cfg(CFG_PHASE_STEP, (1 << PHASE_W) - 1);
        plan_cfg(CFG_REPEAT_ENABLE, 0);
        plan_req(mk_req(FUNC_START, 0, 0, 0, 0), EXP_NONE);
        plan_req(mk_req(FUNC_TICK, 0, 0, 0, 0), EXP_MODEL);
        plan_req(mk_req(FUNC_TICK, 0, 0, 0, 0), EXP_MODEL);
        // Lowering the row count behind the current segment ends playback.
        plan_cfg(CFG_ROW_COUNT, MIN_ROWS);
        plan_req(mk_req(FUNC_TICK, 0, 0, 0, 0), EXP_DONE);

        // No joint enabled: a running tick returns nothing.
        plan_cfg(CFG_JOINT_ENABLE, 0);
        plan_cfg(CFG_REPEAT_ENABLE, 1);
        plan_req(mk_req(FUNC_START, 0, 0, 0, 0), EXP_NONE);
        plan_req(mk_req(FUNC_TICK, 0, 0, 0, 0), EXP_NONE);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
                settings++;
            end else begin
                send(plan[i].req, plan[i].kind);
            end
        end

        // Random phases. The fourth phase is the back-pressure squeeze, and
        // the last stretch runs without idling on either side.
        while (req_total < ITEMS_TOTAL) begin
            phase_no++;
            quiet = (req_total >= ITEMS_TOTAL * 17 / 20);
            run_phase(phase_no == 4);
        end

        quiet = 1'b1;
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d requests: %0d loads, %0d rewinds, %0d ticks, %0d unused codes",
                 req_total + n_unused, n_loads, n_starts, n_ticks, n_unused);
        $display("%0d register writes groups, %0d results checked, %0d of them end of playback",
                 settings, results_seen, done_seen);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
